FILE: design/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the maximum-tracking stack: data width,
// cell operation codes, request codes and result status codes.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   // Operation applied to the cells of a chain.
   typedef logic [2:0] cell_op_type;
   localparam cell_op_type CELL_HOLD = 3'd0;
   localparam cell_op_type CELL_PUSH = 3'd1;  // take the entry from the upper neighbour
   localparam cell_op_type CELL_POP  = 3'd2;  // take the entry from the lower neighbour
   localparam cell_op_type CELL_INC  = 3'd3;  // top pair only: bump the repeat count
   localparam cell_op_type CELL_DEC  = 3'd4;  // top pair only: lower the repeat count

   typedef logic req_kind_type;
   localparam req_kind_type REQ_PUSH = 1'b0;
   localparam req_kind_type REQ_POP  = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_POP_EMPTY = 2'd1;
   localparam status_type STATUS_PUSH_FULL = 2'd2;

endpackage

FILE: design/mts_value_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_value_cell
// One entry of the value stack; shifts down on a push and up on a pop.
// ----------------------------------------------------------------------------
module mts_value_cell (
   input  logic                clock,
   input  mts_pkg::cell_op_type op,
   input  mts_pkg::value_type  upper_value,
   input  mts_pkg::value_type  lower_value,
   output mts_pkg::value_type  value
);
   import mts_pkg::*;

   value_type value_ff;
   value_type value_in;

   always_comb begin
      case (op)
         CELL_PUSH: value_in = upper_value;
         CELL_POP:  value_in = lower_value;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: design/mts_max_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_max_cell
// One (maximum, repeat) pair of the maximum stack.
// ----------------------------------------------------------------------------
module mts_max_cell #(
   parameter int RPT_WIDTH = 5
) (
   input  logic                 clock,
   input  mts_pkg::cell_op_type op,
   input  mts_pkg::value_type   upper_max,
   input  logic [RPT_WIDTH-1:0] upper_rpt,
   input  mts_pkg::value_type   lower_max,
   input  logic [RPT_WIDTH-1:0] lower_rpt,
   output mts_pkg::value_type   max_value,
   output logic [RPT_WIDTH-1:0] rpt
);
   import mts_pkg::*;

   value_type            max_ff;
   value_type            max_in;
   logic [RPT_WIDTH-1:0] rpt_ff;
   logic [RPT_WIDTH-1:0] rpt_in;

   always_comb begin
      max_in = max_ff;
      rpt_in = rpt_ff;
      case (op)
         CELL_PUSH: begin
            max_in = upper_max;
            rpt_in = upper_rpt;
         end
         CELL_POP: begin
            max_in = lower_max;
            rpt_in = lower_rpt;
         end
         CELL_INC: rpt_in = rpt_ff + RPT_WIDTH'(1);
         CELL_DEC: rpt_in = rpt_ff - RPT_WIDTH'(1);
         default: begin
            max_in = max_ff;
            rpt_in = rpt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      rpt_ff <= rpt_in;
   end

   assign max_value = max_ff;
   assign rpt       = rpt_ff;

endmodule

FILE: design/max_tracking_stack_core.sv
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after its request beat is taken.
// Throughput: one request per cycle; both stacks are rows of cells that all
// shift together, so the depth of the stack costs no time.
// busy is high only while reset is asserted. Reset empties both stacks.
// The receiver cannot stall: each result beat stands for one cycle only.
// ----------------------------------------------------------------------------
// max_tracking_stack_core
// LIFO stack of signed values that also reports its current maximum, built
// as two chains of cells: one for the values and one for (maximum, repeat)
// pairs.
// ----------------------------------------------------------------------------
module max_tracking_stack_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mts_pkg::req_kind_type req_type,
   input  mts_pkg::value_type  req_push_value,
   output logic                rsp_valid,
   output mts_pkg::value_type  rsp_popped_value,
   output mts_pkg::value_type  rsp_peak_value,
   output logic                rsp_is_empty,
   output mts_pkg::status_type rsp_status
);
   import mts_pkg::*;

   // Counts must reach STACK_DEPTH itself, and so must a repeat count.
   localparam int CNT_WIDTH = $clog2(STACK_DEPTH + 1);

   logic accept;

   // Occupancy of the two chains. Cell 0 is the top of each stack; cells at
   // or beyond the count hold stale data that is never looked at.
   logic [CNT_WIDTH-1:0] value_count_ff;
   logic [CNT_WIDTH-1:0] value_count_in;
   logic [CNT_WIDTH-1:0] max_count_ff;
   logic [CNT_WIDTH-1:0] max_count_in;

   value_type            cell_value [STACK_DEPTH];
   value_type            cell_max   [STACK_DEPTH];
   logic [CNT_WIDTH-1:0] cell_rpt   [STACK_DEPTH];

   cell_op_type value_op;
   cell_op_type max_top_op;   // the top pair may also count up or down
   cell_op_type max_chain_op; // every other pair only shifts or holds

   // Result register: payload needs no reset, the strobe does.
   logic       rsp_valid_ff;
   value_type  rsp_popped_ff;
   value_type  rsp_popped_in;
   value_type  rsp_max_ff;
   value_type  rsp_max_in;
   logic       rsp_empty_ff;
   logic       rsp_empty_in;
   status_type rsp_status_ff;
   status_type rsp_status_in;

   logic full;
   logic empty;
   logic have_max;

   assign busy   = reset;
   assign accept = start && !busy;

   assign full     = (value_count_ff == CNT_WIDTH'(STACK_DEPTH));
   assign empty    = (value_count_ff == '0);
   assign have_max = (max_count_ff != '0);

   // Decide what the two chains do this cycle.
   always_comb begin
      value_op       = CELL_HOLD;
      max_top_op     = CELL_HOLD;
      value_count_in = value_count_ff;
      max_count_in   = max_count_ff;
      rsp_popped_in  = '0;
      rsp_status_in  = STATUS_OK;

      if (accept) begin
         if (req_type == REQ_PUSH) begin
            if (full) begin
               rsp_status_in = STATUS_PUSH_FULL;
            end else begin
               value_op       = CELL_PUSH;
               value_count_in = value_count_ff + CNT_WIDTH'(1);
               if (!have_max || (req_push_value > cell_max[0])) begin
                  // A new, strictly larger maximum opens a fresh pair.
                  max_top_op   = CELL_PUSH;
                  max_count_in = max_count_ff + CNT_WIDTH'(1);
               end else if (req_push_value == cell_max[0]) begin
                  max_top_op = CELL_INC;
               end
            end
         end else begin
            if (empty) begin
               rsp_status_in = STATUS_POP_EMPTY;
            end else begin
               value_op       = CELL_POP;
               value_count_in = value_count_ff - CNT_WIDTH'(1);
               rsp_popped_in  = cell_value[0];
               if (have_max && (cell_value[0] == cell_max[0])) begin
                  // The last copy of the maximum leaves: drop its pair; else lower its count.
                  if (cell_rpt[0] == CNT_WIDTH'(1)) begin
                     max_top_op   = CELL_POP;
                     max_count_in = max_count_ff - CNT_WIDTH'(1);
                  end else begin
                     max_top_op = CELL_DEC;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      case (max_top_op)
         CELL_PUSH: max_chain_op = CELL_PUSH;
         CELL_POP:  max_chain_op = CELL_POP;
         default:   max_chain_op = CELL_HOLD;
      endcase
   end

   // The maximum after this step is the top pair as it will be next cycle, or zero once empty.
   always_comb begin
      case (max_top_op)
         CELL_PUSH: rsp_max_in = req_push_value;
         CELL_POP:  rsp_max_in = cell_max[1];
         default:   rsp_max_in = cell_max[0];
      endcase
      rsp_empty_in = (value_count_in == '0);
      if (rsp_empty_in) begin
         rsp_max_in = '0;
      end
   end

   // The two chains of cells. The top cell takes the incoming entry on a
   // push; the bottom cell takes zero on a pop.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cells
      value_type            up_value;
      value_type            low_value;
      value_type            up_max;
      value_type            low_max;
      logic [CNT_WIDTH-1:0] up_rpt;
      logic [CNT_WIDTH-1:0] low_rpt;

      if (i == 0) begin : g_top
         assign up_value = req_push_value;
         assign up_max   = req_push_value;
         assign up_rpt   = CNT_WIDTH'(1);
      end else begin : g_mid_up
         assign up_value = cell_value[i-1];
         assign up_max   = cell_max[i-1];
         assign up_rpt   = cell_rpt[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign low_value = '0;
         assign low_max   = '0;
         assign low_rpt   = '0;
      end else begin : g_mid_low
         assign low_value = cell_value[i+1];
         assign low_max   = cell_max[i+1];
         assign low_rpt   = cell_rpt[i+1];
      end

      mts_value_cell u_value_cell (
         .clock       (clock),
         .op          (value_op),
         .upper_value (up_value),
         .lower_value (low_value),
         .value       (cell_value[i])
      );

      mts_max_cell #(
         .RPT_WIDTH (CNT_WIDTH)
      ) u_max_cell (
         .clock     (clock),
         .op        ((i == 0) ? max_top_op : max_chain_op),
         .upper_max (up_max),
         .upper_rpt (up_rpt),
         .lower_max (low_max),
         .lower_rpt (low_rpt),
         .max_value (cell_max[i]),
         .rpt       (cell_rpt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_count_ff <= '0;
         max_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         value_count_ff <= value_count_in;
         max_count_ff   <= max_count_in;
         rsp_valid_ff   <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_popped_ff <= rsp_popped_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_peak_value   = rsp_max_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   // There are never more pairs than stored values.
   a_pairs_bounded: assert property (@(posedge clock) disable iff (reset)
      max_count_ff <= value_count_ff)
      else $error("pair stack deeper than value stack");

   // The pair stack is empty exactly when the value stack is empty.
   a_pairs_track_values: assert property (@(posedge clock) disable iff (reset)
      (max_count_ff == '0) == (value_count_ff == '0))
      else $error("pair stack and value stack disagree on emptiness");

   // Every accepted request gives one result beat in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing result beat");

   // A refused pop leaves the stack reported empty.
   a_pop_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_POP_EMPTY) |-> rsp_is_empty)
      else $error("pop on empty stack reported non-empty");
`endif

endmodule
